/* design/stok_pkg.sv */
// Shared types, constants and byte tables of the source tokenizer.
package stok_pkg;

  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned FIFO_DEPTH    = 4;

  // Scanner modes.
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_NAME    = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_ESCAPE  = 3'd4,
    MODE_PENDING = 3'd5
  } mode_e;

  // Token kinds.
  localparam logic [4:0] KIND_NAME        = 5'd0;
  localparam logic [4:0] KIND_ALIAS       = 5'd1;
  localparam logic [4:0] KIND_NUMBER      = 5'd2;
  localparam logic [4:0] KIND_STRING      = 5'd3;
  localparam logic [4:0] KIND_LONE_BASE   = 5'd4;
  localparam logic [4:0] KIND_PAIR_DOUBLE = 5'd19;
  localparam logic [4:0] KIND_PAIR_SINGLE = 5'd20;
  localparam logic [4:0] KIND_EOF         = 5'd31;

  // Special bytes.
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_CR        = 8'h0d;
  localparam logic [7:0] CHAR_LF        = 8'h0a;
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
  localparam logic [7:0] CHAR_PERIOD    = 8'h2e;
  localparam logic [7:0] CHAR_F         = 8'h66;
  localparam logic [7:0] CHAR_B         = 8'h62;
  localparam logic [7:0] CHAR_H         = 8'h68;

  // Length of the keyword "alias".
  localparam logic [2:0] KW_LENGTH   = 3'd5;
  // Pending operator codes run from zero to this count minus one.
  localparam logic [2:0] PAIR_COUNT  = 3'd6;

  // Small control state of the scanner.
  typedef struct packed {
    mode_e      mode;
    logic [2:0] pend_op;
    logic [2:0] kw_progress;
    logic       kw_possible;
    logic       period_seen;
    logic       suffix_seen;
  } ctl_t;

  localparam ctl_t CTL_RESET = '{
    mode:        MODE_IDLE,
    pend_op:     3'd0,
    kw_progress: 3'd0,
    kw_possible: 1'b1,
    period_seen: 1'b0,
    suffix_seen: 1'b0
  };

  // One result item.
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic        num_err;
    logic        last;
  } token_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } lone_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } pair_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_name_byte(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7a)) ||
           ((c >= 8'h41) && (c <= 8'h5a)) || (c == 8'h5f);
  endfunction

  // Characters of the keyword "alias".
  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h61;
      3'd1:    r = 8'h6c;
      3'd2:    r = 8'h69;
      3'd3:    r = 8'h61;
      3'd4:    r = 8'h73;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Operators that stand alone: + - * / % ( ) [ ] { } ; , . ^
  function automatic lone_t lone_op(input logic [7:0] c);
    lone_t r;
    r.hit = 1'b1;
    r.idx = 4'd0;
    unique case (c)
      8'h2b:   r.idx = 4'd0;
      8'h2d:   r.idx = 4'd1;
      8'h2a:   r.idx = 4'd2;
      8'h2f:   r.idx = 4'd3;
      8'h25:   r.idx = 4'd4;
      8'h28:   r.idx = 4'd5;
      8'h29:   r.idx = 4'd6;
      8'h5b:   r.idx = 4'd7;
      8'h5d:   r.idx = 4'd8;
      8'h7b:   r.idx = 4'd9;
      8'h7d:   r.idx = 4'd10;
      8'h3b:   r.idx = 4'd11;
      8'h2c:   r.idx = 4'd12;
      8'h2e:   r.idx = 4'd13;
      8'h5e:   r.idx = 4'd14;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // First bytes of operators that may pair up: = ! < > & |
  function automatic pair_t pair_first(input logic [7:0] c);
    pair_t r;
    r.hit = 1'b1;
    r.idx = 3'd0;
    unique case (c)
      8'h3d:   r.idx = 3'd0;
      8'h21:   r.idx = 3'd1;
      8'h3c:   r.idx = 3'd2;
      8'h3e:   r.idx = 3'd3;
      8'h26:   r.idx = 3'd4;
      8'h7c:   r.idx = 3'd5;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // Second byte that completes a pair.
  function automatic logic [7:0] pair_second(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd4:    r = 8'h26;
      3'd5:    r = 8'h7c;
      default: r = 8'h3d;
    endcase
    return r;
  endfunction

endpackage

/* design/stok_step.sv */
// Next-state and result logic of the tokenizer for one input item.
module stok_step #(
  parameter int unsigned POSITION_BITS = stok_pkg::POSITION_BITS
) (
  input  logic [7:0]               char_byte_i,
  input  logic                     end_of_source_i,
  input  stok_pkg::ctl_t           ctl_i,
  input  logic [POSITION_BITS-1:0] start_i,
  input  logic [POSITION_BITS-1:0] count_i,
  input  logic [POSITION_BITS-1:0] position_i,
  input  logic [POSITION_BITS-1:0] line_i,
  output stok_pkg::ctl_t           ctl_o,
  output logic [POSITION_BITS-1:0] start_o,
  output logic [POSITION_BITS-1:0] count_o,
  output logic [POSITION_BITS-1:0] position_o,
  output logic [POSITION_BITS-1:0] line_o,
  output stok_pkg::token_t         tok0_o,
  output stok_pkg::token_t         tok1_o,
  output logic [1:0]               push_o
);

  localparam int unsigned P = POSITION_BITS;

  function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
    return (v == '1) ? v : v + P'(1);
  endfunction

  logic [7:0]       c;
  stok_pkg::lone_t  lone;
  stok_pkg::pair_t  pair;
  logic [2:0]       po;

  stok_pkg::ctl_t   idl_ctl;
  logic [P-1:0]     idl_start;
  logic [P-1:0]     idl_count;
  logic             idl_line_inc;
  logic             idl_emit;
  logic [4:0]       idl_kind;

  stok_pkg::token_t first_tok;
  stok_pkg::token_t second_tok;
  logic             first_emit;
  logic             second_emit;
  logic             take_idle;
  logic             kw_match;

  assign c    = char_byte_i;
  assign lone = stok_pkg::lone_op(c);
  assign pair = stok_pkg::pair_first(c);
  assign po   = (ctl_i.pend_op >= stok_pkg::PAIR_COUNT) ? ctl_i.pend_op - stok_pkg::PAIR_COUNT
                                                        : ctl_i.pend_op;
  assign kw_match = ctl_i.kw_possible && (ctl_i.kw_progress < stok_pkg::KW_LENGTH) &&
                    (c == stok_pkg::kw_char(ctl_i.kw_progress));

  // Scan of the byte as if no token were open.
  always_comb begin
    idl_ctl      = ctl_i;
    idl_ctl.mode = stok_pkg::MODE_IDLE;
    idl_start    = start_i;
    idl_count    = count_i;
    idl_line_inc = 1'b0;
    idl_emit     = 1'b0;
    idl_kind     = stok_pkg::KIND_NAME;
    priority if (c == stok_pkg::CHAR_SPACE || c == stok_pkg::CHAR_CR) begin
      idl_line_inc = 1'b0;
    end else if (c == stok_pkg::CHAR_LF) begin
      idl_line_inc = 1'b1;
    end else if (stok_pkg::is_digit(c)) begin
      idl_ctl.mode        = stok_pkg::MODE_NUMBER;
      idl_start           = position_i;
      idl_count           = P'(1);
      idl_ctl.period_seen = 1'b0;
      idl_ctl.suffix_seen = 1'b0;
    end else if (stok_pkg::is_name_byte(c)) begin
      idl_ctl.mode        = stok_pkg::MODE_NAME;
      idl_start           = position_i;
      idl_count           = P'(1);
      idl_ctl.kw_possible = (c == stok_pkg::kw_char(3'd0));
      idl_ctl.kw_progress = (c == stok_pkg::kw_char(3'd0)) ? 3'd1 : 3'd0;
    end else if (c == stok_pkg::CHAR_QUOTE) begin
      idl_ctl.mode = stok_pkg::MODE_STRING;
      idl_start    = sat_inc(position_i);
      idl_count    = '0;
    end else if (lone.hit) begin
      idl_emit = 1'b1;
      idl_kind = stok_pkg::KIND_LONE_BASE + 5'(lone.idx);
    end else if (pair.hit) begin
      idl_ctl.mode    = stok_pkg::MODE_PENDING;
      idl_ctl.pend_op = pair.idx;
      idl_start       = position_i;
    end else begin
      // Any other byte starts no token and is skipped.
      idl_line_inc = 1'b0;
    end
  end

  // Main scanner step: close or extend the open token, then rescan if needed.
  always_comb begin
    ctl_o      = ctl_i;
    start_o    = start_i;
    count_o    = count_i;
    position_o = sat_inc(position_i);
    line_o     = line_i;

    first_emit         = 1'b0;
    take_idle          = 1'b0;
    first_tok.kind     = stok_pkg::KIND_NAME;
    first_tok.start    = 16'(start_i);
    first_tok.length   = 16'(count_i);
    first_tok.line     = 16'(line_i);
    first_tok.num_err  = 1'b0;
    first_tok.last     = 1'b0;

    second_emit        = 1'b0;
    second_tok.kind    = idl_kind;
    second_tok.start   = 16'(position_i);
    second_tok.length  = 16'd1;
    second_tok.line    = 16'(line_i);
    second_tok.num_err = 1'b0;
    second_tok.last    = 1'b1;

    if (end_of_source_i) begin
      // Flush the open token, then EOF, then back to the reset state.
      unique case (ctl_i.mode)
        stok_pkg::MODE_NAME: begin
          first_emit     = 1'b1;
          first_tok.kind = (ctl_i.kw_possible && ctl_i.kw_progress == stok_pkg::KW_LENGTH)
                           ? stok_pkg::KIND_ALIAS : stok_pkg::KIND_NAME;
        end
        stok_pkg::MODE_NUMBER: begin
          first_emit     = 1'b1;
          first_tok.kind = stok_pkg::KIND_NUMBER;
        end
        stok_pkg::MODE_STRING, stok_pkg::MODE_ESCAPE: begin
          first_emit     = 1'b1;
          first_tok.kind = stok_pkg::KIND_STRING;
        end
        stok_pkg::MODE_PENDING: begin
          first_emit       = 1'b1;
          first_tok.kind   = stok_pkg::KIND_PAIR_SINGLE + 5'({po, 1'b0});
          first_tok.length = 16'd1;
        end
        default: first_emit = 1'b0;
      endcase
      second_emit       = 1'b1;
      second_tok.kind   = stok_pkg::KIND_EOF;
      second_tok.start  = 16'(position_i);
      second_tok.length = 16'd0;
      ctl_o      = stok_pkg::CTL_RESET;
      start_o    = '0;
      count_o    = '0;
      position_o = '0;
      line_o     = '0;
    end else begin
      unique case (ctl_i.mode)
        stok_pkg::MODE_NAME: begin
          if (stok_pkg::is_name_byte(c)) begin
            count_o = sat_inc(count_i);
            if (kw_match) begin
              ctl_o.kw_progress = ctl_i.kw_progress + 3'd1;
            end else begin
              ctl_o.kw_possible = 1'b0;
            end
          end else begin
            first_emit     = 1'b1;
            first_tok.kind = (ctl_i.kw_possible && ctl_i.kw_progress == stok_pkg::KW_LENGTH)
                             ? stok_pkg::KIND_ALIAS : stok_pkg::KIND_NAME;
            take_idle      = 1'b1;
          end
        end
        stok_pkg::MODE_NUMBER: begin
          first_tok.kind = stok_pkg::KIND_NUMBER;
          if (stok_pkg::is_digit(c)) begin
            count_o = sat_inc(count_i);
          end else if (c == stok_pkg::CHAR_PERIOD) begin
            if (!ctl_i.period_seen) begin
              ctl_o.period_seen = 1'b1;
              count_o           = sat_inc(count_i);
            end else begin
              first_emit        = 1'b1;
              first_tok.num_err = 1'b1;
              take_idle         = 1'b1;
            end
          end else if (c == stok_pkg::CHAR_F || c == stok_pkg::CHAR_B ||
                       c == stok_pkg::CHAR_H) begin
            if (!ctl_i.suffix_seen) begin
              ctl_o.suffix_seen = 1'b1;
              count_o           = sat_inc(count_i);
            end else begin
              first_emit        = 1'b1;
              first_tok.num_err = 1'b1;
              take_idle         = 1'b1;
            end
          end else begin
            first_emit = 1'b1;
            take_idle  = 1'b1;
          end
        end
        stok_pkg::MODE_STRING: begin
          if (c == stok_pkg::CHAR_QUOTE) begin
            first_emit     = 1'b1;
            first_tok.kind = stok_pkg::KIND_STRING;
            ctl_o.mode     = stok_pkg::MODE_IDLE;
          end else begin
            count_o = sat_inc(count_i);
            if (c == stok_pkg::CHAR_BACKSLASH) begin
              ctl_o.mode = stok_pkg::MODE_ESCAPE;
            end
          end
        end
        stok_pkg::MODE_ESCAPE: begin
          count_o    = sat_inc(count_i);
          ctl_o.mode = stok_pkg::MODE_STRING;
        end
        stok_pkg::MODE_PENDING: begin
          first_emit = 1'b1;
          if (c == stok_pkg::pair_second(po)) begin
            first_tok.kind   = stok_pkg::KIND_PAIR_DOUBLE + 5'({po, 1'b0});
            first_tok.length = 16'd2;
            ctl_o.mode       = stok_pkg::MODE_IDLE;
          end else begin
            first_tok.kind   = stok_pkg::KIND_PAIR_SINGLE + 5'({po, 1'b0});
            first_tok.length = 16'd1;
            take_idle        = 1'b1;
          end
        end
        default: take_idle = 1'b1;
      endcase

      // Rescan of the byte once the open token is closed.
      if (take_idle) begin
        ctl_o       = idl_ctl;
        start_o     = idl_start;
        count_o     = idl_count;
        line_o      = idl_line_inc ? sat_inc(line_i) : line_i;
        second_emit = idl_emit;
      end
    end
  end

  // Pack up to two results; the last one carries the end-of-run mark.
  always_comb begin
    tok0_o = first_tok;
    tok1_o = second_tok;
    push_o = 2'b00;
    if (first_emit) begin
      tok0_o.last = !second_emit;
      push_o      = second_emit ? 2'b11 : 2'b01;
    end else if (second_emit) begin
      tok0_o = second_tok;
      push_o = 2'b01;
    end
  end

endmodule

/* design/stok_fifo.sv */
// Result queue of the tokenizer that takes up to two items per cycle.
module stok_fifo (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic [1:0]                               push_i,
  input  stok_pkg::token_t                         wr_data0_i,
  input  stok_pkg::token_t                         wr_data1_i,
  input  logic                                     pop_i,
  output stok_pkg::token_t                         rd_data_o,
  output logic [$clog2(stok_pkg::FIFO_DEPTH+1)-1:0] fill_o
);

  // The depth is a power of two, so the pointers wrap on their own.
  localparam int unsigned AW = $clog2(stok_pkg::FIFO_DEPTH);
  localparam int unsigned CW = $clog2(stok_pkg::FIFO_DEPTH + 1);

  stok_pkg::token_t entry_q [stok_pkg::FIFO_DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [CW-1:0]    push_count;

  assign push_count = CW'(push_i[0]) + CW'(push_i[1]);
  assign wr_ptr_d   = wr_ptr_q + AW'(push_count);
  assign rd_ptr_d   = rd_ptr_q + AW'(pop_i);
  assign fill_d     = fill_q + push_count - CW'(pop_i);

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Entry storage; the second item goes one place after the first.
  always_ff @(posedge clk_i) begin
    if (push_i[0]) begin
      entry_q[wr_ptr_q] <= wr_data0_i;
    end
    if (push_i[1]) begin
      entry_q[wr_ptr_q + AW'(1)] <= wr_data1_i;
    end
  end

  assign rd_data_o = entry_q[rd_ptr_q];
  assign fill_o    = fill_q;

endmodule

/* design/source_tokenizer.sv */
// Top level of the source tokenizer: scanner state, step logic and result queue.
//
// Source text enters one byte per item on the input channel (char_byte_i, or
// end_of_source_i to close the source). Tokens leave one per item on the output
// channel as kind, start offset, length, line, number error flag and a mark on
// the last token that one input item caused.
// Each input item is scanned by the combinational step logic and produces zero,
// one or two tokens; these are written into a four-entry result queue, so the
// first token is offered in the cycle after the item is accepted.
// The block accepts an input item in every cycle while the queue has room for
// two more tokens; the input stall is raised from the queue fill alone, so the
// sustained rate is one byte per cycle as long as the receiver keeps up.
// When the receiver stalls, the head token holds steady and the queue fills;
// once fewer than two places remain, the input stalls until tokens drain.
// An end-of-source item flushes any open token, emits EOF and returns the
// scanner to its reset state, so the next byte begins a new source.
// Reset empties the queue and sets the scanner to idle at offset and line zero.
// Offsets, lengths and line counts saturate at 2^POSITION_BITS - 1 and are
// shown on 16-bit ports.
module source_tokenizer #(
  parameter int unsigned POSITION_BITS = stok_pkg::POSITION_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_byte_i,
  input  logic        end_of_source_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  token_kind_o,
  output logic [15:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic [15:0] line_number_o,
  output logic        number_error_o,
  output logic        last_of_run_o
);

  localparam int unsigned P  = POSITION_BITS;
  localparam int unsigned CW = $clog2(stok_pkg::FIFO_DEPTH + 1);

  stok_pkg::ctl_t   ctl_q, ctl_d;
  logic [P-1:0]     start_q, start_d;
  logic [P-1:0]     count_q, count_d;
  logic [P-1:0]     position_q, position_d;
  logic [P-1:0]     line_q, line_d;

  stok_pkg::token_t tok0, tok1, head;
  logic [1:0]       step_push;
  logic [1:0]       push;
  logic [CW-1:0]    fill;
  logic             in_accept;
  logic             out_pop;

  assign in_stall_o = fill > CW'(stok_pkg::FIFO_DEPTH - 2);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign push       = in_accept ? step_push : 2'b00;

  // Scanner step for the item at the input.
  stok_step #(
    .POSITION_BITS(P)
  ) u_step (
    .char_byte_i    (char_byte_i),
    .end_of_source_i(end_of_source_i),
    .ctl_i          (ctl_q),
    .start_i        (start_q),
    .count_i        (count_q),
    .position_i     (position_q),
    .line_i         (line_q),
    .ctl_o          (ctl_d),
    .start_o        (start_d),
    .count_o        (count_d),
    .position_o     (position_d),
    .line_o         (line_d),
    .tok0_o         (tok0),
    .tok1_o         (tok1),
    .push_o         (step_push)
  );

  // Scanner state, advanced on each accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q      <= stok_pkg::CTL_RESET;
      start_q    <= '0;
      count_q    <= '0;
      position_q <= '0;
      line_q     <= '0;
    end else if (in_accept) begin
      ctl_q      <= ctl_d;
      start_q    <= start_d;
      count_q    <= count_d;
      position_q <= position_d;
      line_q     <= line_d;
    end
  end

  // Result queue between the scanner and the output channel.
  stok_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data0_i(tok0),
    .wr_data1_i(tok1),
    .pop_i     (out_pop),
    .rd_data_o (head),
    .fill_o    (fill)
  );

  assign out_valid_o    = fill != '0;
  assign out_pop        = out_valid_o && !out_stall_i;
  assign token_kind_o   = head.kind;
  assign start_offset_o = head.start;
  assign token_length_o = head.length;
  assign line_number_o  = head.line;
  assign number_error_o = head.num_err;
  assign last_of_run_o  = head.last;

`ifndef SYNTHESIS
  // The queue never holds more items than it has places.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= CW'(stok_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  // An accepted end of source always leaves at least its EOF token queued.
  a_eof_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && end_of_source_i) |=> out_valid_o)
    else $error("no token after end of source");

  // End of source returns offset and line count to zero.
  a_eof_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && end_of_source_i) |=> (position_q == '0 && line_q == '0))
    else $error("position not cleared after end of source");

  // An open name or number always holds at least one byte.
  a_open_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q.mode == stok_pkg::MODE_NAME || ctl_q.mode == stok_pkg::MODE_NUMBER)
    |-> count_q != '0)
    else $error("open token with zero length");
`endif

endmodule

/* sim/source_tokenizer_tb.sv */
// Self-checking testbench of the source tokenizer with its own scanner model.
module source_tokenizer_tb;
  import stok_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 100;
  localparam int TAIL_CYCLES    = 8;
  localparam int REPORT_LIMIT   = 20;

  localparam string LONE_OPS     = "+-*/%()[]{};,.^";
  localparam string PAIR_OPEN    = "=!<>&|";
  localparam string PAIR_CLOSE   = "====&|";
  localparam string KEYWORD      = "alias";
  localparam string WORD_SET     =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";
  localparam string SPACERS      = " \r\n";
  localparam string NUMBER_MARKS = ".fbh";

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } src_item_t;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  in_byte   = 8'h00;
  logic        in_end    = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [4:0]  token_kind_o;
  logic [15:0] start_offset_o;
  logic [15:0] token_length_o;
  logic [15:0] line_number_o;
  logic        number_error_o;
  logic        last_of_run_o;

  src_item_t source_bytes[$];
  token_t    tokens_due[$];

  int send_gap     = 0;
  int send_calm    = 0;
  int recv_gap     = 0;
  int recv_calm    = 0;
  int hold_left    = 0;
  bit held         = 1'b0;
  int results_seen = 0;
  int mismatches   = 0;
  int idle_cycles  = 0;

  // Scanner state of the model.
  mode_e       cur_mode;
  logic [2:0]  op_code;
  logic [15:0] tok_start;
  logic [15:0] tok_len;
  logic [15:0] src_pos;
  logic [15:0] src_line;
  logic        dot_seen;
  logic        sfx_seen;
  logic [2:0]  kw_pos;
  logic        kw_ok;

  source_tokenizer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .char_byte_i     (in_byte),
    .end_of_source_i (in_end),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .token_kind_o    (token_kind_o),
    .start_offset_o  (start_offset_o),
    .token_length_o  (token_length_o),
    .line_number_o   (line_number_o),
    .number_error_o  (number_error_o),
    .last_of_run_o   (last_of_run_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scanner model
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] sat_up(logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  function automatic logic dec_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic word_byte(logic [7:0] c);
    return dec_digit(c) || ((c >= "a") && (c <= "z")) ||
           ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic int find_byte(string set, logic [7:0] c);
    for (int i = 0; i < set.len(); i++) begin
      if (set[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic void clear_scanner();
    cur_mode  = MODE_IDLE;
    op_code   = 3'd0;
    tok_start = 16'd0;
    tok_len   = 16'd0;
    src_pos   = 16'd0;
    src_line  = 16'd0;
    dot_seen  = 1'b0;
    sfx_seen  = 1'b0;
    kw_pos    = 3'd0;
    kw_ok     = 1'b1;
  endfunction

  function automatic void queue_token(logic [4:0] kind, logic [15:0] start,
                                      logic [15:0] len, logic err);
    token_t t;
    t.kind    = kind;
    t.start   = start;
    t.length  = len;
    t.line    = src_line;
    t.num_err = err;
    t.last    = 1'b0;
    tokens_due.push_back(t);
  endfunction

  // Follows how far a name still matches the keyword.
  function automatic void kw_track(logic [7:0] c);
    if (kw_ok && (kw_pos < KW_LENGTH) && (c == KEYWORD[kw_pos])) kw_pos++;
    else kw_ok = 1'b0;
  endfunction

  function automatic void name_done();
    queue_token((kw_ok && (kw_pos == KW_LENGTH)) ? KIND_ALIAS : KIND_NAME,
                tok_start, tok_len, 1'b0);
  endfunction

  // A byte seen with no token open: skip it, count a line or open a token.
  function automatic void scan_idle(logic [7:0] c);
    int op;
    cur_mode = MODE_IDLE;
    if ((c == CHAR_SPACE) || (c == CHAR_CR)) return;
    if (c == CHAR_LF) begin
      src_line = sat_up(src_line);
      return;
    end
    if (dec_digit(c)) begin
      cur_mode  = MODE_NUMBER;
      tok_start = src_pos;
      tok_len   = 16'd1;
      dot_seen  = 1'b0;
      sfx_seen  = 1'b0;
      return;
    end
    if (word_byte(c)) begin
      cur_mode  = MODE_NAME;
      tok_start = src_pos;
      tok_len   = 16'd1;
      kw_pos    = 3'd0;
      kw_ok     = 1'b1;
      kw_track(c);
      return;
    end
    if (c == CHAR_QUOTE) begin
      cur_mode  = MODE_STRING;
      tok_start = sat_up(src_pos);
      tok_len   = 16'd0;
      return;
    end
    op = find_byte(LONE_OPS, c);
    if (op >= 0) begin
      queue_token(KIND_LONE_BASE + 5'(op), src_pos, 16'd1, 1'b0);
      return;
    end
    op = find_byte(PAIR_OPEN, c);
    if (op >= 0) begin
      cur_mode  = MODE_PENDING;
      op_code   = 3'(op);
      tok_start = src_pos;
    end
  endfunction

  // Works out the tokens that one accepted item causes.
  function automatic void scan_item(logic [7:0] c, logic fin);
    int had;
    had = tokens_due.size();
    if (fin) begin
      case (cur_mode)
        MODE_NAME:                name_done();
        MODE_NUMBER:              queue_token(KIND_NUMBER, tok_start, tok_len, 1'b0);
        MODE_STRING, MODE_ESCAPE: queue_token(KIND_STRING, tok_start, tok_len, 1'b0);
        MODE_PENDING: queue_token(KIND_PAIR_SINGLE + {1'b0, op_code, 1'b0},
                                  tok_start, 16'd1, 1'b0);
        default: ;
      endcase
      queue_token(KIND_EOF, src_pos, 16'd0, 1'b0);
      clear_scanner();
    end else begin
      case (cur_mode)
        MODE_NAME: begin
          if (word_byte(c)) begin
            tok_len = sat_up(tok_len);
            kw_track(c);
          end else begin
            name_done();
            scan_idle(c);
          end
        end
        MODE_NUMBER: begin
          if (dec_digit(c)) begin
            tok_len = sat_up(tok_len);
          end else if ((c == CHAR_PERIOD) || (c == CHAR_F) || (c == CHAR_B) ||
                       (c == CHAR_H)) begin
            // A second period or suffix ends the number and is scanned afresh.
            if ((c == CHAR_PERIOD) ? dot_seen : sfx_seen) begin
              queue_token(KIND_NUMBER, tok_start, tok_len, 1'b1);
              scan_idle(c);
            end else begin
              if (c == CHAR_PERIOD) dot_seen = 1'b1;
              else sfx_seen = 1'b1;
              tok_len = sat_up(tok_len);
            end
          end else begin
            queue_token(KIND_NUMBER, tok_start, tok_len, 1'b0);
            scan_idle(c);
          end
        end
        MODE_STRING: begin
          if (c == CHAR_QUOTE) begin
            queue_token(KIND_STRING, tok_start, tok_len, 1'b0);
            cur_mode = MODE_IDLE;
          end else begin
            tok_len = sat_up(tok_len);
            if (c == CHAR_BACKSLASH) cur_mode = MODE_ESCAPE;
          end
        end
        MODE_ESCAPE: begin
          tok_len  = sat_up(tok_len);
          cur_mode = MODE_STRING;
        end
        MODE_PENDING: begin
          if (c == PAIR_CLOSE[op_code]) begin
            queue_token(KIND_PAIR_DOUBLE + {1'b0, op_code, 1'b0}, tok_start, 16'd2, 1'b0);
            cur_mode = MODE_IDLE;
          end else begin
            queue_token(KIND_PAIR_SINGLE + {1'b0, op_code, 1'b0}, tok_start, 16'd1, 1'b0);
            scan_idle(c);
          end
        end
        default: scan_idle(c);
      endcase
      src_pos = sat_up(src_pos);
    end
    if (tokens_due.size() > had) tokens_due[tokens_due.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Source text
  // ---------------------------------------------------------------------------

  function automatic void put_byte(logic [7:0] c);
    src_item_t s;
    s.ch  = c;
    s.fin = 1'b0;
    source_bytes.push_back(s);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  // The byte that goes with the end mark is ignored, so it is random.
  function automatic void end_source();
    src_item_t s;
    s.ch  = 8'($urandom_range(0, 255));
    s.fin = 1'b1;
    source_bytes.push_back(s);
  endfunction

  // Appends one random token, or a byte that starts none.
  function automatic void add_token(bit closing);
    int n;
    case ($urandom_range(0, 9))
      0, 1: begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 3))
            0:       put_text("alias");
            1:       put_text("alia");
            2:       put_text("aliasx");
            default: put_text("xalias");
          endcase
        end else begin
          put_byte(WORD_SET[$urandom_range(0, 52)]);
          n = $urandom_range(0, 5);
          repeat (n) put_byte(WORD_SET[$urandom_range(0, 62)]);
        end
      end
      2, 3: begin
        n = $urandom_range(1, 4);
        repeat (n) put_byte(8'($urandom_range(48, 57)));
        if ($urandom_range(0, 1)) begin
          put_byte(CHAR_PERIOD);
          n = $urandom_range(0, 3);
          repeat (n) put_byte(8'($urandom_range(48, 57)));
        end
        if ($urandom_range(0, 1)) put_byte(NUMBER_MARKS[$urandom_range(1, 3)]);
        if ($urandom_range(0, 2) == 0) put_byte(NUMBER_MARKS[$urandom_range(0, 3)]);
      end
      4: begin
        put_byte(CHAR_QUOTE);
        n = $urandom_range(0, 6);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: begin
              put_byte(CHAR_BACKSLASH);
              put_byte(8'($urandom_range(0, 255)));
            end
            1:       put_byte(8'($urandom_range(0, 255)));
            2:       put_byte(CHAR_LF);
            default: put_byte(WORD_SET[$urandom_range(0, 62)]);
          endcase
        end
        // A string last in its source is sometimes left open.
        if (!closing || ($urandom_range(0, 2) != 0)) put_byte(CHAR_QUOTE);
      end
      5, 6: put_byte(LONE_OPS[$urandom_range(0, 14)]);
      7: begin
        n = $urandom_range(0, 5);
        put_byte(PAIR_OPEN[n]);
        if ($urandom_range(0, 1)) put_byte(PAIR_CLOSE[n]);
        else if ($urandom_range(0, 1)) put_byte(PAIR_OPEN[$urandom_range(0, 5)]);
      end
      8:       put_byte(SPACERS[$urandom_range(0, 2)]);
      default: put_byte(8'($urandom_range(0, 255)));
    endcase
  endfunction

  // Idle length: mostly none, some short, a few long, with calm stretches.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    int mark;
    int n_tok;
    clear_scanner();

    // Keyword ended by a zero byte, then a number ended by a second suffix.
    put_text("alias");
    put_byte(8'h00);
    put_text("1.5hh");
    end_source();
    // Open string with an escaped quote, a zero byte, a line feed and 0xff.
    put_byte(CHAR_QUOTE);
    put_byte(CHAR_BACKSLASH);
    put_byte(CHAR_QUOTE);
    put_byte(8'h00);
    put_byte(CHAR_LF);
    put_byte(8'hff);
    end_source();
    // A pair, then the first byte of another pair left pending at the end of the source.
    put_text("<=!");
    end_source();
    // A second period ends the number and becomes an operator.
    put_text("7..x");
    end_source();

    // Random sources of random tokens.
    mark = source_bytes.size();
    while (source_bytes.size() - mark < RANDOM_ITEMS) begin
      n_tok = $urandom_range(1, 12);
      for (int t = 0; t < n_tok; t++) begin
        add_token(t == n_tok - 1);
        if ($urandom_range(0, 1)) put_byte(SPACERS[$urandom_range(0, 2)]);
      end
      end_source();
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((source_bytes.size() != 0) || in_valid) @(posedge clk_i);
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("source_tokenizer: match");
    end else begin
      $display("source_tokenizer: mismatch");
    end
    $finish;
  end

  // Sender: offers queued bytes with random gaps and holds them while stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    src_item_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_byte  <= 8'h00;
      in_end   <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall_o) send_gap = pick_gap(send_calm);
      if (in_valid && in_stall_o) begin
        // The offered item stays as it is.
      end else if ((send_gap == 0) && (source_bytes.size() != 0)) begin
        nxt = source_bytes.pop_front();
        in_valid <= 1'b1;
        in_byte  <= nxt.ch;
        in_end   <= nxt.fin;
      end else begin
        in_valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end
    end
  end

  // Receiver: checks each token, predicts from each accepted byte, and stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    token_t got;
    token_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      recv_gap  = 0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        got.kind    = token_kind_o;
        got.start   = start_offset_o;
        got.length  = token_length_o;
        got.line    = line_number_o;
        got.num_err = number_error_o;
        got.last    = last_of_run_o;
        results_seen++;
        if (tokens_due.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: expected no token, actual kind %0d start %0d length %0d line %0d",
                     $time, got.kind, got.start, got.length, got.line);
          mismatches++;
        end else begin
          want = tokens_due.pop_front();
          if (got !== want) begin
            if (mismatches < REPORT_LIMIT) begin
              $display("%0t: expected kind %0d start %0d length %0d line %0d err %0b last %0b",
                       $time, want.kind, want.start, want.length, want.line,
                       want.num_err, want.last);
              $display("%0t: actual   kind %0d start %0d length %0d line %0d err %0b last %0b",
                       $time, got.kind, got.start, got.length, got.line,
                       got.num_err, got.last);
            end
            mismatches++;
          end
        end
        recv_gap = pick_gap(recv_calm);
      end

      if (in_valid && !in_stall_o) scan_item(in_byte, in_end);

      // One long hold-off lets the result queue fill and stall the input.
      if (!held && (results_seen == HOLD_AFTER)) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("source_tokenizer: mismatch");
        $finish;
      end
    end
  end

endmodule
